/* design/stmfir_pkg.sv */
// ----------------------------------------------------------------------------
// stmfir_pkg - shared types and constants for the stereo-to-mono FIR
// Widths of the datapath, coefficient reset values and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package stmfir_pkg;

  // filter geometry
  localparam int TAPS      = 16;
  localparam int HALF_TAPS = TAPS / 2;
  localparam int HIST_LEN  = TAPS - 1;

  // datapath widths
  localparam int SAMPLE_W  = 16;                 // input and output samples
  localparam int MONO_W    = SAMPLE_W + 1;       // left + right, one fraction bit
  localparam int PAIR_W    = MONO_W + 1;         // symmetric tap pre-add
  localparam int COEF_W    = 16;                 // Q1.15 weight
  localparam int PROD_W    = COEF_W + PAIR_W;    // one lane product
  localparam int PSUM_W    = PROD_W + 1;         // sum of two lanes
  localparam int ACC_W     = PSUM_W + 2;         // sum of all lanes
  localparam int FRAC_BITS = 16;                 // accumulator scale 2^-16
  localparam int QUO_W     = ACC_W - FRAC_BITS;  // scaled result before clamp
  localparam int NUM_PSUM  = HALF_TAPS / 2;

  // configuration port
  localparam int NUM_REGS  = HALF_TAPS;
  localparam int IDX_W     = $clog2(NUM_REGS);
  localparam int ADDR_W    = IDX_W + 2;
  localparam int APB_W     = 32;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [MONO_W-1:0]   mono_t;
  typedef logic signed [PAIR_W-1:0]   pair_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [PSUM_W-1:0]   psum_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [QUO_W-1:0]    quo_t;

  typedef coef_t coef_arr_t [HALF_TAPS];
  typedef pair_t pair_arr_t [HALF_TAPS];

  // register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_COEF_A,
    REG_COEF_B,
    REG_COEF_C,
    REG_COEF_D,
    REG_COEF_E,
    REG_COEF_F,
    REG_COEF_G,
    REG_COEF_H
  } reg_idx_t;

  // weights after reset: outer tap pair first
  localparam coef_t COEF_RESET [HALF_TAPS] = '{
    coef_t'(-4313), coef_t'(3402), coef_t'(3163), coef_t'(3352),
    coef_t'(3725),  coef_t'(4124), coef_t'(4448), coef_t'(4625)
  };

endpackage

`default_nettype wire

/* design/stmfir_in_if.sv */
// ----------------------------------------------------------------------------
// stmfir_in_if - stereo sample request channel
// Valid/ready channel carrying one left/right pair and a block-start flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface stmfir_in_if import stmfir_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t left_sample;
  sample_t right_sample;
  logic    block_start;

  modport source (output valid, left_sample, right_sample, block_start, input ready);
  modport sink   (input valid, left_sample, right_sample, block_start, output ready);
endinterface

`default_nettype wire

/* design/stmfir_out_if.sv */
// ----------------------------------------------------------------------------
// stmfir_out_if - mono sample request channel
// Valid/ready channel carrying one filtered sample and its clip flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface stmfir_out_if import stmfir_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t out_sample;
  logic    clipped;

  modport source (output valid, out_sample, clipped, input ready);
  modport sink   (input valid, out_sample, clipped, output ready);
endinterface

`default_nettype wire

/* design/stmfir_regs.sv */
// ----------------------------------------------------------------------------
// stmfir_regs - coefficient register file
// APB-style write/read access to the eight symmetric Q1.15 weights.
// ----------------------------------------------------------------------------
`default_nettype none

module stmfir_regs import stmfir_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [APB_W-1:0]  pwdata,
  output logic      [APB_W-1:0]  prdata,
  output logic                   pready,
  output coef_arr_t              coefs
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      coefs <= COEF_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_COEF_A: coefs[0] <= coef_t'(pwdata[COEF_W-1:0]);
        REG_COEF_B: coefs[1] <= coef_t'(pwdata[COEF_W-1:0]);
        REG_COEF_C: coefs[2] <= coef_t'(pwdata[COEF_W-1:0]);
        REG_COEF_D: coefs[3] <= coef_t'(pwdata[COEF_W-1:0]);
        REG_COEF_E: coefs[4] <= coef_t'(pwdata[COEF_W-1:0]);
        REG_COEF_F: coefs[5] <= coef_t'(pwdata[COEF_W-1:0]);
        REG_COEF_G: coefs[6] <= coef_t'(pwdata[COEF_W-1:0]);
        REG_COEF_H: coefs[7] <= coef_t'(pwdata[COEF_W-1:0]);
        default: ;
      endcase
    end
  end

  // read back, sign extended
  assign prdata = APB_W'(coefs[idx]);

endmodule

`default_nettype wire

/* design/stmfir_taps.sv */
// ----------------------------------------------------------------------------
// stmfir_taps - mono mix, delay line and symmetric pre-add
// Sums each stereo pair to mono, keeps the last fifteen mono values and
// registers the eight folded tap sums.
// ----------------------------------------------------------------------------
`default_nettype none

module stmfir_taps import stmfir_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  stmfir_in_if.sink    src,
  output logic         pair_valid,
  input  wire logic    pair_ready,
  output pair_arr_t    pairs
);

  logic      accept;
  mono_t     mono;
  mono_t     history [HIST_LEN];
  mono_t     taps    [TAPS];
  pair_arr_t pairs_next;

  assign src.ready = !pair_valid || pair_ready;
  assign accept    = src.valid && src.ready;

  // exact mono value, one fraction bit
  assign mono = MONO_W'(src.left_sample) + MONO_W'(src.right_sample);

  // tap view with block start clearing old history
  always_comb begin
    taps[0] = mono;
    for (int j = 1; j < TAPS; j++) begin
      taps[j] = src.block_start ? '0 : history[j-1];
    end
  end

  // fold symmetric taps
  always_comb begin
    for (int k = 0; k < HALF_TAPS; k++) begin
      pairs_next[k] = PAIR_W'(taps[k]) + PAIR_W'(taps[TAPS-1-k]);
    end
  end

  // delay line shifts on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < HIST_LEN; j++) history[j] <= '0;
    end else if (accept) begin
      history[0] <= mono;
      for (int j = 1; j < HIST_LEN; j++) history[j] <= taps[j];
    end
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
    end else if (src.ready) begin
      pair_valid <= src.valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      pairs <= pairs_next;
    end
  end

endmodule

`default_nettype wire

/* design/stmfir_mac.sv */
// ----------------------------------------------------------------------------
// stmfir_mac - weight, sum, scale and clamp
// Three register stages: lane products, partial sums, then the final sum
// truncated toward zero and saturated into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module stmfir_mac import stmfir_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       pair_valid,
  output logic            pair_ready,
  input  pair_arr_t       pairs,
  input  coef_arr_t       coefs,
  stmfir_out_if.source    dst
);

  localparam quo_t Q_MAX = QUO_W'((1 <<< (SAMPLE_W-1)) - 1);
  localparam quo_t Q_MIN = QUO_W'(-(1 <<< (SAMPLE_W-1)));

  logic    prod_valid;
  logic    psum_valid;
  logic    out_valid;
  logic    ld_prod;
  logic    ld_psum;
  logic    ld_out;
  prod_t   prods [HALF_TAPS];
  psum_t   psums [NUM_PSUM];
  acc_t    acc;
  logic    round_up;
  quo_t    quo;
  sample_t sample_next;
  logic    clip_next;
  sample_t out_sample;
  logic    clipped;

  // stage loads: a stage takes new data when empty or draining
  assign ld_out     = !out_valid || dst.ready;
  assign ld_psum    = !psum_valid || ld_out;
  assign ld_prod    = !prod_valid || ld_psum;
  assign pair_ready = ld_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      psum_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (ld_prod) prod_valid <= pair_valid;
      if (ld_psum) psum_valid <= prod_valid;
      if (ld_out)  out_valid  <= psum_valid;
    end
  end

  // lane products
  always_ff @(posedge clk) begin
    if (ld_prod) begin
      for (int k = 0; k < HALF_TAPS; k++) begin
        prods[k] <= PROD_W'(coefs[k]) * PROD_W'(pairs[k]);
      end
    end
  end

  // partial sums of lane pairs
  always_ff @(posedge clk) begin
    if (ld_psum) begin
      for (int i = 0; i < NUM_PSUM; i++) begin
        psums[i] <= PSUM_W'(prods[2*i]) + PSUM_W'(prods[2*i+1]);
      end
    end
  end

  // final sum, divide by 2^16 toward zero, clamp to int16
  always_comb begin
    acc = '0;
    for (int i = 0; i < NUM_PSUM; i++) begin
      acc = acc + ACC_W'(psums[i]);
    end
    round_up = acc[ACC_W-1] && (acc[FRAC_BITS-1:0] != '0);
    quo      = quo_t'(acc >>> FRAC_BITS) + QUO_W'(round_up);
    if (quo > Q_MAX) begin
      sample_next = sample_t'(Q_MAX);
      clip_next   = 1'b1;
    end else if (quo < Q_MIN) begin
      sample_next = sample_t'(Q_MIN);
      clip_next   = 1'b1;
    end else begin
      sample_next = sample_t'(quo);
      clip_next   = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_sample <= sample_next;
      clipped    <= clip_next;
    end
  end

  assign dst.valid      = out_valid;
  assign dst.out_sample = out_sample;
  assign dst.clipped    = clipped;

endmodule

`default_nettype wire

/* design/blockwise_stereo_to_mono_fir16.sv */
// ----------------------------------------------------------------------------
// blockwise_stereo_to_mono_fir16 - stereo-to-mono 16-tap symmetric FIR
// Mixes each stereo pair to mono and filters it with programmable weights.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake              payload
//   stereo    in    valid / ready          left_sample, right_sample, block_start
//   mono      out   valid / ready          out_sample, clipped
//   apb       in    psel/penable/pready    coef_a .. coef_h at 4*i
//
// One request per cycle sustained while the mono output is ready; the pre-add
// is registered on the taking edge, then the multiply, the partial sum, and the
// final sum and clamp are each registered in turn.
// Every stage holds its data while the one after it is full and stalled,
// so a waiting result does not block requests until all stages are full.
// Synchronous reset empties the pipeline, zeros the delay line and loads
// the default weights.
// ----------------------------------------------------------------------------
`default_nettype none

module blockwise_stereo_to_mono_fir16 import stmfir_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  stmfir_in_if.sink              stereo,
  stmfir_out_if.source           mono,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [APB_W-1:0]  pwdata,
  output logic      [APB_W-1:0]  prdata,
  output logic                   pready
);

  coef_arr_t coefs;
  pair_arr_t pairs;
  logic      pair_valid;
  logic      pair_ready;

  // coefficient registers
  stmfir_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coefs   (coefs)
  );

  // mono mix and delay line
  stmfir_taps u_taps (
    .clk        (clk),
    .rst        (rst),
    .src        (stereo),
    .pair_valid (pair_valid),
    .pair_ready (pair_ready),
    .pairs      (pairs)
  );

  // weighting and output
  stmfir_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .pair_valid (pair_valid),
    .pair_ready (pair_ready),
    .pairs      (pairs),
    .coefs      (coefs),
    .dst        (mono)
  );

endmodule

`default_nettype wire
